[src/ste_pkg.sv]
// Shared types and constants for the software timer event table.
package ste_pkg;

    // Default sizes
    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int TAG_BITS_DEF  = 16;

    // Input operation codes (tuser of the input stream)
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    // Schedule result codes
    localparam logic SCHED_STORED = 1'b0;
    localparam logic SCHED_FULL   = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SCHED,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_tick;
        logic load_sched;
        logic scan;
        logic update;
        logic sched;
        logic emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic slot_free;
        logic table_full;
        logic out_free;
    } status_t;

endpackage

[src/ste_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[src/ste_ctrl.sv]
// Controller state machine: sequences tick scans and schedule searches.
module ste_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  ste_pkg::status_t  sts,
    output ste_pkg::cmd_t     cmd
);

    ste_pkg::state_t state_reg;
    ste_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ste_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ste_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_op == ste_pkg::OP_SCHEDULE) ? ste_pkg::ST_SCHED
                                                                 : ste_pkg::ST_SCAN;
                end
            end
            ste_pkg::ST_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = ste_pkg::ST_UPDATE;
                end
                else if (sts.scan_end)
                begin
                    state_next = ste_pkg::ST_DONE;
                end
            end
            ste_pkg::ST_UPDATE:
            begin
                state_next = ste_pkg::ST_DONE;
            end
            ste_pkg::ST_SCHED:
            begin
                if (sts.slot_free || sts.table_full)
                begin
                    state_next = ste_pkg::ST_DONE;
                end
            end
            ste_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ste_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ste_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = (state_reg == ste_pkg::ST_IDLE);
        cmd.load_tick  = (state_reg == ste_pkg::ST_IDLE) && in_valid
                         && (in_op == ste_pkg::OP_TICK);
        cmd.load_sched = (state_reg == ste_pkg::ST_IDLE) && in_valid
                         && (in_op == ste_pkg::OP_SCHEDULE);
        cmd.scan       = (state_reg == ste_pkg::ST_SCAN);
        cmd.update     = (state_reg == ste_pkg::ST_UPDATE);
        cmd.sched      = (state_reg == ste_pkg::ST_SCHED);
        cmd.emit       = (state_reg == ste_pkg::ST_DONE);
    end

endmodule

[src/ste_dp.sv]
// Datapath: time counter, slot table, valid bits, scan pointer and output register.
module ste_dp #(
    parameter int NUM_SLOTS = ste_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = ste_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS  = ste_pkg::TAG_BITS_DEF,
    localparam int SLOT_W   = $clog2(NUM_SLOTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ste_pkg::cmd_t        cmd,
    output ste_pkg::status_t     sts,
    input  logic [TIME_BITS-1:0] in_due,
    input  logic [TIME_BITS-1:0] in_period,
    input  logic [TAG_BITS-1:0]  in_tag,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 out_fired,
    output logic [SLOT_W-1:0]    out_fired_slot,
    output logic [TAG_BITS-1:0]  out_fired_tag,
    output logic                 out_status,
    output logic [SLOT_W-1:0]    out_assigned,
    output logic [TIME_BITS-1:0] out_time
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int RAM_W = 2 * TIME_BITS + TAG_BITS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(NUM_SLOTS);

    // Control state
    logic [TIME_BITS-1:0] time_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 cmp_vld_reg;
    logic                 out_valid_reg;

    // Payload
    logic [TIME_BITS-1:0] due_reg;
    logic [TIME_BITS-1:0] period_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [SLOT_W-1:0]    cmp_idx_reg;
    logic [TIME_BITS-1:0] hit_period_reg;
    logic                 res_fired_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [TAG_BITS-1:0]  res_tag_reg;
    logic                 res_status_reg;
    logic [SLOT_W-1:0]    res_assigned_reg;
    logic                 out_fired_reg;
    logic [SLOT_W-1:0]    out_fired_slot_reg;
    logic [TAG_BITS-1:0]  out_fired_tag_reg;
    logic                 out_status_reg;
    logic [SLOT_W-1:0]    out_assigned_reg;
    logic [TIME_BITS-1:0] out_time_reg;

    // RAM signals
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [RAM_W-1:0]     ram_rdata;

    logic [SLOT_W-1:0]    idx;
    logic                 cnt_in_range;
    logic [TIME_BITS-1:0] rd_due;
    logic [TIME_BITS-1:0] rd_period;
    logic [TAG_BITS-1:0]  rd_tag;
    logic                 hit;
    logic                 out_free;
    logic                 load_any;

    // Slot table: word is {tag, period, due}
    ste_ram #(
        .WIDTH(RAM_W),
        .DEPTH(NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Scan pointer and read decode
    assign idx          = cnt_reg[SLOT_W-1:0];
    assign cnt_in_range = (cnt_reg < CNT_END);
    assign ram_raddr    = cnt_in_range ? idx : '0;
    assign rd_due       = ram_rdata[TIME_BITS-1:0];
    assign rd_period    = ram_rdata[2*TIME_BITS-1:TIME_BITS];
    assign rd_tag       = ram_rdata[RAM_W-1:2*TIME_BITS];
    assign load_any     = cmd.load_tick || cmd.load_sched;

    // Due check on the slot read last cycle
    assign hit      = cmp_vld_reg && valid_reg[cmp_idx_reg] && (time_reg >= rd_due);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.hit        = hit;
        sts.scan_end   = cmp_vld_reg && (cmp_idx_reg == LAST_SLOT) && !hit;
        sts.slot_free  = !valid_reg[idx];
        sts.table_full = valid_reg[idx] && (idx == LAST_SLOT);
        sts.out_free   = out_free;
    end

    // Table write: store a new event or rearm a fired one
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx;
        ram_wdata = {tag_reg, period_reg, due_reg};
        if (cmd.update)
        begin
            ram_we    = (hit_period_reg != '0);
            ram_waddr = res_slot_reg;
            ram_wdata = {res_tag_reg, hit_period_reg, time_reg + hit_period_reg};
        end
        else if (cmd.sched)
        begin
            ram_we = !valid_reg[idx];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_tick)
            begin
                time_reg <= time_reg + TIME_BITS'(1);
            end

            if (load_any)
            begin
                cnt_reg     <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (cnt_in_range)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                cmp_vld_reg <= cnt_in_range;
            end
            else if (cmd.sched)
            begin
                if (valid_reg[idx])
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                else
                begin
                    valid_reg[idx] <= 1'b1;
                end
            end

            // one-shot event frees its slot
            if (cmd.update && (hit_period_reg == '0))
            begin
                valid_reg[res_slot_reg] <= 1'b0;
            end

            if (cmd.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_any)
        begin
            due_reg          <= in_due;
            period_reg       <= in_period;
            tag_reg          <= in_tag;
            res_fired_reg    <= 1'b0;
            res_slot_reg     <= '0;
            res_tag_reg      <= '0;
            res_status_reg   <= ste_pkg::SCHED_STORED;
            res_assigned_reg <= '0;
        end

        if (cmd.scan)
        begin
            cmp_idx_reg <= idx;
            if (hit)
            begin
                res_fired_reg  <= 1'b1;
                res_slot_reg   <= cmp_idx_reg;
                res_tag_reg    <= rd_tag;
                hit_period_reg <= rd_period;
            end
        end

        if (cmd.sched)
        begin
            if (!valid_reg[idx])
            begin
                res_assigned_reg <= idx;
                res_status_reg   <= ste_pkg::SCHED_STORED;
            end
            else if (idx == LAST_SLOT)
            begin
                res_status_reg <= ste_pkg::SCHED_FULL;
            end
        end

        if (cmd.emit && out_free)
        begin
            out_fired_reg      <= res_fired_reg;
            out_fired_slot_reg <= res_slot_reg;
            out_fired_tag_reg  <= res_tag_reg;
            out_status_reg     <= res_status_reg;
            out_assigned_reg   <= res_assigned_reg;
            out_time_reg       <= time_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_fired      = out_fired_reg;
    assign out_fired_slot = out_fired_slot_reg;
    assign out_fired_tag  = out_fired_tag_reg;
    assign out_status     = out_status_reg;
    assign out_assigned   = out_assigned_reg;
    assign out_time       = out_time_reg;

endmodule

[src/software_timer_event_table.sv]
// Top level of the software timer event table.
//
// Input stream (s_axis): one word per request. tuser selects the operation:
// tick (advance the time counter by one and fire at most one due event) or
// schedule (store a new event in the lowest free slot). tdata carries the
// due time, repeat period and tag; they are ignored on a tick.
// Output stream (m_axis): exactly one result word per request, carrying the
// fired slot and tag, the schedule status and slot, and the time counter.
// Throughput: one request at a time. A tick walks the slot table one slot a
// cycle through the table RAM's single read port; when a slot fires, the
// UPDATE state writes the rearmed due time back. A schedule walks the
// valid bits.
// Reset clears the time counter and all valid bits at once; the table RAM
// itself is not cleared since only written slots are ever valid.
// A result sits in the output register until taken; the block accepts the
// next request meanwhile and holds that one's result back while stalled.
module software_timer_event_table #(
    parameter int NUM_SLOTS  = ste_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS  = ste_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS   = ste_pkg::TAG_BITS_DEF,
    localparam int SLOT_W    = $clog2(NUM_SLOTS),
    localparam int IN_BITS   = 2 * TIME_BITS + TAG_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS  = 2 * SLOT_W + TAG_BITS + TIME_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // due_time, repeat_period, event_tag (from bit 0 up), zero padded
    input  logic [IN_W-1:0]  s_axis_tdata,
    // operation
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // fired_slot, fired_tag, assigned_slot, current_time (from bit 0 up), zero padded
    output logic [OUT_W-1:0] m_axis_tdata,
    // fired, schedule_status (from bit 0 up)
    output logic [1:0]       m_axis_tuser
);

    ste_pkg::cmd_t        cmd;
    ste_pkg::status_t     sts;

    logic                 out_fired;
    logic [SLOT_W-1:0]    out_fired_slot;
    logic [TAG_BITS-1:0]  out_fired_tag;
    logic                 out_status;
    logic [SLOT_W-1:0]    out_assigned;
    logic [TIME_BITS-1:0] out_time;

    ste_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ste_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_due         (s_axis_tdata[TIME_BITS-1:0]),
        .in_period      (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
        .in_tag         (s_axis_tdata[IN_BITS-1:2*TIME_BITS]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_fired      (out_fired),
        .out_fired_slot (out_fired_slot),
        .out_fired_tag  (out_fired_tag),
        .out_status     (out_status),
        .out_assigned   (out_assigned),
        .out_time       (out_time)
    );

    // Result word packing
    assign m_axis_tdata = OUT_W'({out_time, out_assigned, out_fired_tag, out_fired_slot});
    assign m_axis_tuser = {out_status, out_fired};

endmodule

[src/ste_checker.sv]
// Port-level checks for the software timer event table, bound to the top level.
module ste_checker #(
    parameter int NUM_SLOTS  = ste_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS  = ste_pkg::TIME_BITS_DEF,
    parameter int TAG_BITS   = ste_pkg::TAG_BITS_DEF,
    localparam int SLOT_W    = $clog2(NUM_SLOTS),
    localparam int OUT_BITS  = 2 * SLOT_W + TAG_BITS + TIME_BITS,
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);

    // Output register is empty once a reset edge has been seen
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result word valid during reset");

    // One request in flight: no back-to-back accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous request still in progress");

    // Stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // A result is either a tick or a schedule answer, never both flags
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("fired and no-free-slot flags both set");

    // Nothing fired: slot and tag fields are cleared
    a_nofire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0])
            |-> (m_axis_tdata[SLOT_W+TAG_BITS-1:0] == '0))
        else $error("fired slot or tag nonzero with nothing fired");

endmodule

bind software_timer_event_table ste_checker #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS)
) u_ste_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
